@@ hw/rtl/bta_pkg.sv @@
package bta_pkg;

  localparam int BLOCKS   = 64;
  localparam int TAG_BITS = 16;

  localparam int NEED_W = 7;
  localparam int TAG_W  = 16;
  localparam int FREE_W = 7;

  localparam int IDX_BITS   = $clog2(BLOCKS);
  localparam int COUNT_BITS = $clog2(BLOCKS + 1);
  localparam int CMP_BITS   = (TAG_BITS > TAG_W) ? TAG_BITS : TAG_W;

  localparam int IN_DATA_W  = 8 * ((NEED_W + TAG_W + 7) / 8);
  localparam int OUT_DATA_W = 8 * ((TAG_W + FREE_W + 7) / 8);

  localparam logic [TAG_BITS-1:0] TAG_MAX = '1;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RECYCLE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic                we;
    logic [TAG_BITS-1:0] wdata;
    logic                take;
    logic                hit;
  } entry_ctl_t;

endpackage

@@ hw/rtl/tagged_block_allocator.sv @@
// First-fit block allocator over a 64-entry owner table. An allocate (tuser 0) of N
// blocks issues the next tag and gives it to the first N free entries; a recycle
// (tuser 1) frees every entry that holds the given tag. Every request returns one
// beat with the success flag, the issued tag and the free count. A request that
// passes the up-front checks walks the whole table through one read-modify-write
// pipeline on the table RAM, one entry per cycle, before its result is formed; a
// request rejected by the checks skips the walk and goes to its result. The table is
// usable straight after reset: per-entry valid flops make unwritten entries free.
module tagged_block_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bta_pkg::IN_DATA_W-1:0]   s_tdata,   // block_count, owner_tag, zero pad
  input  logic                            s_tuser,   // opcode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bta_pkg::OUT_DATA_W-1:0]  m_tdata,   // issued_tag, free_blocks, zero pad
  output logic                            m_tuser    // success
);

  localparam int IW = bta_pkg::IDX_BITS;
  localparam int CB = bta_pkg::COUNT_BITS;
  localparam int PAD_W = bta_pkg::OUT_DATA_W - bta_pkg::TAG_W - bta_pkg::FREE_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                          state;
  bta_pkg::opcode_t                op_r;
  logic [bta_pkg::CMP_BITS-1:0]    key_r;
  logic [bta_pkg::TAG_BITS-1:0]    tag_r;
  logic [bta_pkg::TAG_BITS-1:0]    last_tag;
  logic [CB-1:0]                   free_count;
  logic [CB-1:0]                   left;
  logic [IW:0]                     scan_idx;
  logic                            pend;
  logic [IW-1:0]                   pidx;
  logic                            rd_vld;
  logic [bta_pkg::BLOCKS-1:0]      vld;
  logic                            res_ok;
  logic [bta_pkg::TAG_W-1:0]       res_tag;
  logic [bta_pkg::FREE_W-1:0]      res_free;

  logic [bta_pkg::NEED_W-1:0]      in_need;
  logic [bta_pkg::TAG_W-1:0]       in_tag;
  logic [bta_pkg::CMP_BITS-1:0]    in_key;
  logic                            alloc_bad;
  logic                            recyc_bad;
  logic                            accept;
  logic                            re;
  logic [IW-1:0]                   raddr;
  logic [bta_pkg::TAG_BITS-1:0]    rdata;
  logic                            scan_end;
  logic                            out_free;
  bta_pkg::entry_ctl_t             ctl;

  assign in_need  = s_tdata[bta_pkg::NEED_W-1:0];
  assign in_tag   = s_tdata[bta_pkg::NEED_W +: bta_pkg::TAG_W];
  assign in_key   = bta_pkg::CMP_BITS'(in_tag);
  assign alloc_bad = (in_need == '0) || (32'(in_need) > 32'(free_count))
                     || (last_tag == bta_pkg::TAG_MAX);
  assign recyc_bad = (in_tag == '0)
                     || (in_key > bta_pkg::CMP_BITS'(bta_pkg::TAG_MAX));

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign scan_end = (scan_idx == (IW + 1)'(bta_pkg::BLOCKS));
  assign re       = (state == ST_SCAN) && !scan_end;
  assign raddr    = scan_idx[IW-1:0];
  assign out_free = !m_tvalid || m_tready;

  bta_ram #(
    .WIDTH (bta_pkg::TAG_BITS),
    .DEPTH (bta_pkg::BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (pend && ctl.we),
    .waddr (pidx),
    .wdata (ctl.wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  bta_entry_unit u_entry (
    .op        (op_r),
    .key       (key_r),
    .tag       (tag_r),
    .left_zero (left == '0),
    .ent_vld   (rd_vld),
    .ent_tag   (rdata),
    .ctl       (ctl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      op_r       <= bta_pkg::OP_ALLOC;
      last_tag   <= '0;
      free_count <= CB'(bta_pkg::BLOCKS);
      vld        <= '0;
      pend       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op_r     <= bta_pkg::opcode_t'(s_tuser);
            key_r    <= in_key;
            scan_idx <= '0;
            pend     <= 1'b0;
            if (s_tuser == bta_pkg::OP_RECYCLE) begin
              res_ok <= 1'b0;
              state  <= recyc_bad ? ST_DONE : ST_SCAN;
            end else if (alloc_bad) begin
              res_ok <= 1'b0;
              state  <= ST_DONE;
            end else begin
              res_ok     <= 1'b1;
              tag_r      <= last_tag + 1'b1;
              last_tag   <= last_tag + 1'b1;
              free_count <= free_count - CB'(in_need);
              left       <= CB'(in_need);
              state      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (re) begin
            rd_vld   <= vld[raddr];
            pidx     <= raddr;
            scan_idx <= scan_idx + 1'b1;
          end
          pend <= re;
          if (pend) begin
            if (ctl.we) begin
              vld[pidx] <= 1'b1;
            end
            if (ctl.take) begin
              left <= left - 1'b1;
            end
            if (ctl.hit) begin
              res_ok <= 1'b1;
              if (free_count < CB'(bta_pkg::BLOCKS)) begin
                free_count <= free_count + 1'b1;
              end
            end
          end
          if (scan_end && !pend) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tuser  <= res_ok;
            res_tag  <= (res_ok && op_r == bta_pkg::OP_ALLOC)
                        ? bta_pkg::TAG_W'(bta_pkg::CMP_BITS'(tag_r)) : '0;
            res_free <= bta_pkg::FREE_W'(free_count);
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, res_free, res_tag};

endmodule

@@ hw/rtl/bta_ram.sv @@
module bta_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/bta_entry_unit.sv @@
module bta_entry_unit (
  input  bta_pkg::opcode_t                  op,
  input  logic [bta_pkg::CMP_BITS-1:0]      key,
  input  logic [bta_pkg::TAG_BITS-1:0]      tag,
  input  logic                              left_zero,
  input  logic                              ent_vld,
  input  logic [bta_pkg::TAG_BITS-1:0]      ent_tag,
  output bta_pkg::entry_ctl_t               ctl
);

  logic ent_free;
  logic ent_match;

  assign ent_free  = !ent_vld || (ent_tag == '0);
  assign ent_match = ent_vld && (bta_pkg::CMP_BITS'(ent_tag) == key);

  always_comb begin
    ctl = '0;
    unique case (op)
      bta_pkg::OP_ALLOC: begin
        ctl.take  = ent_free && !left_zero;
        ctl.we    = ctl.take;
        ctl.wdata = tag;
      end
      bta_pkg::OP_RECYCLE: begin
        ctl.hit   = ent_match;
        ctl.we    = ent_match;
        ctl.wdata = '0;
      end
      default: ctl = '0;
    endcase
  end

endmodule

@@ tb/tb_top.sv @@
module tb_top;

  localparam int N_SCRIPT     = 22;
  localparam int RANDOM_ITEMS = 700;
  localparam int TAIL_ITEMS   = 100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam int IW           = bta_pkg::IDX_BITS;
  localparam int PAD_W        = bta_pkg::IN_DATA_W - bta_pkg::NEED_W - bta_pkg::TAG_W;

  typedef struct packed {
    logic                       ok;
    logic [bta_pkg::TAG_W-1:0]  tag;
    logic [bta_pkg::FREE_W-1:0] blocks_left;
  } reply_t;

  typedef struct packed {
    bta_pkg::opcode_t           op;
    logic [bta_pkg::NEED_W-1:0] need;
    logic [bta_pkg::TAG_W-1:0]  tag;
    logic                       typed;
    reply_t                     want;
  } script_row_t;

  // rows with typed=0 take their expected reply from the allocator model
  localparam script_row_t SCRIPT [N_SCRIPT] = '{
    '{bta_pkg::OP_ALLOC,   7'd0,   16'h0000, 1'b1, '{1'b0, 16'd0, 7'd64}},
    '{bta_pkg::OP_ALLOC,   7'd65,  16'h0000, 1'b1, '{1'b0, 16'd0, 7'd64}},
    '{bta_pkg::OP_ALLOC,   7'd127, 16'hFFFF, 1'b1, '{1'b0, 16'd0, 7'd64}},
    '{bta_pkg::OP_RECYCLE, 7'd127, 16'h0000, 1'b1, '{1'b0, 16'd0, 7'd64}},
    '{bta_pkg::OP_RECYCLE, 7'd0,   16'hFFFF, 1'b1, '{1'b0, 16'd0, 7'd64}},
    '{bta_pkg::OP_ALLOC,   7'd64,  16'h0000, 1'b1, '{1'b1, 16'd1, 7'd0}},
    '{bta_pkg::OP_ALLOC,   7'd1,   16'h0000, 1'b1, '{1'b0, 16'd0, 7'd0}},
    '{bta_pkg::OP_RECYCLE, 7'd0,   16'h0001, 1'b1, '{1'b1, 16'd0, 7'd64}},
    '{bta_pkg::OP_RECYCLE, 7'd0,   16'h0001, 1'b1, '{1'b0, 16'd0, 7'd64}},
    '{bta_pkg::OP_ALLOC,   7'd1,   16'h0000, 1'b1, '{1'b1, 16'd2, 7'd63}},
    '{bta_pkg::OP_ALLOC,   7'd3,   16'h0000, 1'b0, '0},
    '{bta_pkg::OP_ALLOC,   7'd2,   16'h0000, 1'b0, '0},
    '{bta_pkg::OP_RECYCLE, 7'd0,   16'h0003, 1'b0, '0},
    '{bta_pkg::OP_ALLOC,   7'd5,   16'hAAAA, 1'b0, '0},
    '{bta_pkg::OP_RECYCLE, 7'h55,  16'h0002, 1'b0, '0},
    '{bta_pkg::OP_ALLOC,   7'h2A,  16'h5555, 1'b0, '0},
    '{bta_pkg::OP_ALLOC,   7'd16,  16'h0000, 1'b0, '0},
    '{bta_pkg::OP_ALLOC,   7'd15,  16'h0000, 1'b0, '0},
    '{bta_pkg::OP_RECYCLE, 7'd0,   16'h0004, 1'b0, '0},
    '{bta_pkg::OP_RECYCLE, 7'd0,   16'h0005, 1'b0, '0},
    '{bta_pkg::OP_RECYCLE, 7'd0,   16'h0006, 1'b0, '0},
    '{bta_pkg::OP_RECYCLE, 7'd0,   16'h0007, 1'b0, '0}
  };

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [bta_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                           s_tuser = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [bta_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           m_tuser;

  logic [bta_pkg::TAG_BITS-1:0] owner_of [bta_pkg::BLOCKS];
  int unsigned                  blocks_free;
  logic [bta_pkg::TAG_BITS-1:0] newest_tag;

  reply_t      replies_due [$];
  bit          failed = 1'b0;
  bit          calm = 1'b0;
  int unsigned cycle_count = 0;
  int          stall_left = 0;

  always #10 clk = ~clk;

  tagged_block_allocator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  function automatic reply_t predict_reply(bta_pkg::opcode_t op,
                                           logic [bta_pkg::NEED_W-1:0] need,
                                           logic [bta_pkg::TAG_W-1:0] tag);
    reply_t r;
    int     left;
    r = '0;
    if (op == bta_pkg::OP_ALLOC) begin
      if (need != '0 && 32'(need) <= blocks_free && newest_tag != bta_pkg::TAG_MAX) begin
        newest_tag = newest_tag + 1'b1;
        blocks_free = blocks_free - 32'(need);
        left = int'(need);
        for (int i = 0; i < bta_pkg::BLOCKS && left != 0; i++) begin
          if (owner_of[IW'(i)] == '0) begin
            owner_of[IW'(i)] = newest_tag;
            left--;
          end
        end
        r.ok  = 1'b1;
        r.tag = newest_tag;
      end
    end else if (tag != '0) begin
      for (int i = 0; i < bta_pkg::BLOCKS; i++) begin
        if (owner_of[IW'(i)] == tag) begin
          owner_of[IW'(i)] = '0;
          blocks_free++;
          r.ok = 1'b1;
        end
      end
    end
    r.blocks_left = blocks_free[bta_pkg::FREE_W-1:0];
    return r;
  endfunction

  task automatic send_req(input bta_pkg::opcode_t op, input logic [bta_pkg::NEED_W-1:0] need,
                          input logic [bta_pkg::TAG_W-1:0] tag, input logic typed,
                          input reply_t want);
    reply_t predicted;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{PAD_W{1'b0}}, tag, need};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = predict_reply(op, need, tag);
    replies_due.push_back(typed ? want : predicted);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || calm) begin
      stall_left = 0;
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = int'($urandom_range(1, 19)) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch_replies
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (replies_due.size() == 0) begin
        $error("reply beat with no request outstanding");
        failed = 1'b1;
      end else begin
        want = replies_due.pop_front();
        check_field("success", 32'(want.ok), 32'(m_tuser));
        check_field("issued_tag", 32'(want.tag), 32'(m_tdata[bta_pkg::TAG_W-1:0]));
        check_field("free_blocks", 32'(want.blocks_left),
                    32'(m_tdata[bta_pkg::TAG_W +: bta_pkg::FREE_W]));
      end
    end
  end

  initial begin
    int                         k;
    bta_pkg::opcode_t           op;
    logic [bta_pkg::NEED_W-1:0] need;
    logic [bta_pkg::TAG_W-1:0]  tag;
    for (int i = 0; i < bta_pkg::BLOCKS; i++) owner_of[IW'(i)] = '0;
    blocks_free = bta_pkg::BLOCKS;
    newest_tag  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_SCRIPT; r++) begin
      send_req(SCRIPT[r].op, SCRIPT[r].need, SCRIPT[r].tag, SCRIPT[r].typed, SCRIPT[r].want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n >= RANDOM_ITEMS - TAIL_ITEMS) calm = 1'b1;
      k = int'($urandom_range(0, 99));
      if (k < 52) begin
        op  = bta_pkg::OP_ALLOC;
        tag = bta_pkg::TAG_W'($urandom);
        if (k < 4) need = '0;
        else if (k < 7) need = bta_pkg::NEED_W'($urandom_range(65, 127));
        else if (k < 12) need = bta_pkg::NEED_W'($urandom_range(17, 64));
        else need = bta_pkg::NEED_W'($urandom_range(1, 16));
      end else begin
        op   = bta_pkg::OP_RECYCLE;
        need = bta_pkg::NEED_W'($urandom_range(0, 127));
        k    = int'($urandom_range(0, 99));
        if (k < 75) tag = owner_of[IW'($urandom_range(0, bta_pkg::BLOCKS - 1))];
        else if (k < 85) tag = newest_tag - bta_pkg::TAG_W'($urandom_range(0, 3));
        else tag = bta_pkg::TAG_W'($urandom);
      end
      send_req(op, need, tag, 1'b0, '0);
    end

    s_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
